@@ rtl/neighborhood_3x3_pixel_classifier_defines.svh @@
// Assertion macros shared by the checker of the 3x3 pixel classifier.
// Needs a clk and a rst signal in the scope where a macro is used.
`ifndef NEIGHBORHOOD_3X3_PIXEL_CLASSIFIER_DEFINES_SVH
`define NEIGHBORHOOD_3X3_PIXEL_CLASSIFIER_DEFINES_SVH

// same-cycle implication, off while in reset
`define N3PC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("n3pc check failed");

// next-cycle implication, off while in reset
`define N3PC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("n3pc check failed");

`endif

@@ rtl/n3pc_pkg.sv @@
// Shared types, constants and neighbor tables of the 3x3 pixel classifier.
// No dependencies; used by every RTL module of the block but n3pc_ram.
package n3pc_pkg;

  localparam int MAX_SIDE    = 256;
  localparam int PIXEL_BITS  = 8;
  localparam int ADDR_BITS   = 16;
  localparam int STORE_DEPTH = 1 << ADDR_BITS;
  localparam int CFG_BITS    = 9;
  localparam int SIDE_BITS   = $clog2(MAX_SIDE) + 1;   // holds 1..MAX_SIDE
  localparam int COORD_BITS  = $clog2(MAX_SIDE);       // holds 0..MAX_SIDE-1
  localparam int COORD_IDX_W = (COORD_BITS > 1) ? $clog2(COORD_BITS) : 1;
  localparam int DIV_W       = SIDE_BITS + COORD_BITS;
  localparam int AREA_W      = 2 * SIDE_BITS;
  localparam int NBR_COUNT   = 8;
  localparam int NBR_W       = 3;
  localparam int CNT_W       = (COORD_IDX_W > NBR_W) ? COORD_IDX_W : NBR_W;
  localparam int COUNT_W     = 4;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

  // request kinds (tuser)
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // side codes
  localparam logic [1:0] SIDE_TOP    = 2'd0;
  localparam logic [1:0] SIDE_RIGHT  = 2'd1;
  localparam logic [1:0] SIDE_BOTTOM = 2'd2;
  localparam logic [1:0] SIDE_LEFT   = 2'd3;

  // neighbor order: tl, t, tr, l, r, bl, b, br
  typedef logic signed [1:0] delta_t;
  localparam delta_t NBR_DX [NBR_COUNT] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1,
                                            2'sd1, -2'sd1, 2'sd0, 2'sd1};
  localparam delta_t NBR_DY [NBR_COUNT] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
                                            2'sd0, 2'sd1, 2'sd1, 2'sd1};

  typedef struct packed {
    logic                   load;      // capture the accepted request
    logic                   wr;        // store its pixel
    logic                   div_step;  // one restoring-division step
    logic [COORD_IDX_W-1:0] div_bit;   // quotient bit of this step
    logic                   rd_en;     // issue a neighbor read
    logic [NBR_W-1:0]       nbr;       // neighbor being read
    logic                   cap;       // read data of previous issue is valid
    logic                   out_load;  // load the result register
  } cmd_t;

  typedef struct packed {
    logic bad;       // query index outside the image
    logic out_free;  // result register can take a new result
  } stat_t;

endpackage

@@ rtl/n3pc_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module n3pc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/n3pc_ctrl.sv @@
// Sequencer of the classifier: accept, divide, eight neighbor reads, result.
// Depends on n3pc_pkg.
module n3pc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            s_tuser,
  output logic            s_tready,
  input  n3pc_pkg::stat_t stat,
  output n3pc_pkg::cmd_t  cmd
);
  import n3pc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_LAST = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd          = '0;
    cmd.div_bit  = COORD_IDX_W'(CNT_W'(COORD_BITS - 1) - cnt);
    cmd.nbr      = cnt[NBR_W-1:0];
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          cnt_next = '0;
          if (s_tuser == OP_WRITE) begin
            cmd.wr = 1'b1;
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.bad) begin
          state_next = ST_DONE;
        end else if (cnt == CNT_W'(COORD_BITS - 1)) begin
          cnt_next   = '0;
          state_next = ST_READ;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        cmd.cap   = (cnt != '0);
        if (cnt == CNT_W'(NBR_COUNT - 1)) begin
          state_next = ST_LAST;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      ST_LAST: begin
        cmd.cap    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

@@ rtl/n3pc_dp.sv @@
// Datapath: config registers, index divider, neighbor addressing, pixel
// store, flag logic and result register. Depends on n3pc_pkg and n3pc_ram.
module n3pc_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [n3pc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [n3pc_pkg::CFG_BITS-1:0]   cfg_data,
  input  logic [n3pc_pkg::IN_TDATA_W-1:0] s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [n3pc_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  n3pc_pkg::cmd_t                  cmd,
  output n3pc_pkg::stat_t                 stat
);
  import n3pc_pkg::*;

  logic [CFG_BITS-1:0]   width_reg, height_reg;
  logic [SIDE_BITS-1:0]  w_eff, h_eff;
  logic [AREA_W-1:0]     area;
  logic [ADDR_BITS-1:0]  idx;
  logic [PIXEL_BITS-1:0] color;
  logic [1:0]            side;
  logic [DIV_W-1:0]      rem;
  logic [COORD_BITS-1:0] quo;
  logic [DIV_W-1:0]      div_sub;
  logic [COORD_BITS-1:0] x, y;
  logic [NBR_COUNT-1:0]  eq_bits, zero_bits;
  logic                  rd_inside, nbr_inside;
  logic                  ok_x, ok_y;
  logic [ADDR_BITS-1:0]  row_addr, nbr_addr, ram_addr;
  logic [PIXEL_BITS-1:0] ram_rdata;
  logic [COUNT_W-1:0]    pop;
  logic                  bord, irr;
  logic tl, t, tr, l, r, bl, b, br;

  function automatic logic [SIDE_BITS-1:0] eff_side(input logic [CFG_BITS-1:0] v);
    logic [SIDE_BITS-1:0] res;
    if (v == '0) begin
      res = SIDE_BITS'(1);
    end else if (32'(v) > MAX_SIDE) begin
      res = SIDE_BITS'(MAX_SIDE);
    end else begin
      res = SIDE_BITS'(v);
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= CFG_BITS'(256);
      height_reg <= CFG_BITS'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_reg  <= cfg_data;
        REG_HEIGHT: height_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = eff_side(width_reg);
  assign h_eff = eff_side(height_reg);

  // area, registered; config must be stable long before a query (user's duty)
  always_ff @(posedge clk) begin
    area <= AREA_W'(w_eff) * AREA_W'(h_eff);
  end

  assign stat.bad      = AREA_W'(idx) >= area;
  assign stat.out_free = !m_tvalid || m_tready;

  // request capture and restoring division idx / w (quotient fits COORD_BITS)
  assign div_sub = DIV_W'(w_eff) << cmd.div_bit;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx   <= s_tdata[15:0];
      color <= s_tdata[31:24];
      side  <= s_tdata[33:32];
      rem   <= DIV_W'(s_tdata[15:0]);
      quo   <= '0;
    end else if (cmd.div_step && (rem >= div_sub)) begin
      rem          <= rem - div_sub;
      quo[cmd.div_bit] <= 1'b1;
    end
  end

  assign x = rem[COORD_BITS-1:0];
  assign y = quo;

  // neighbor address and bounds
  always_comb begin
    case (NBR_DX[cmd.nbr])
      -2'sd1:  ok_x = (x != '0);
      2'sd1:   ok_x = ((SIDE_BITS'(x) + SIDE_BITS'(1)) != w_eff);
      default: ok_x = 1'b1;
    endcase
    case (NBR_DY[cmd.nbr])
      -2'sd1:  ok_y = (y != '0);
      2'sd1:   ok_y = ((SIDE_BITS'(y) + SIDE_BITS'(1)) != h_eff);
      default: ok_y = 1'b1;
    endcase
    case (NBR_DY[cmd.nbr])
      -2'sd1:  row_addr = idx - ADDR_BITS'(w_eff);
      2'sd1:   row_addr = idx + ADDR_BITS'(w_eff);
      default: row_addr = idx;
    endcase
    case (NBR_DX[cmd.nbr])
      -2'sd1:  nbr_addr = row_addr - ADDR_BITS'(1);
      2'sd1:   nbr_addr = row_addr + ADDR_BITS'(1);
      default: nbr_addr = row_addr;
    endcase
  end

  assign nbr_inside = ok_x && ok_y;
  assign ram_addr   = cmd.wr ? s_tdata[15:0] : nbr_addr;

  n3pc_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr),
    .addr  (ram_addr),
    .wdata (s_tdata[23:16]),
    .rdata (ram_rdata)
  );

  // read results shift in at the top; neighbor 0 ends in bit 0
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_inside <= nbr_inside;
    end
    if (cmd.cap) begin
      eq_bits   <= {!rd_inside || (ram_rdata == color), eq_bits[NBR_COUNT-1:1]};
      zero_bits <= {!rd_inside || (ram_rdata == '0), zero_bits[NBR_COUNT-1:1]};
    end
  end

  always_comb begin
    pop = '0;
    for (int i = 0; i < NBR_COUNT; i++) begin
      pop = pop + COUNT_W'(eq_bits[i]);
    end
  end

  assign {br, b, bl, r, l, tr, t, tl} = zero_bits;

  always_comb begin
    case (side)
      SIDE_TOP: begin
        bord = !t && b;
        irr  = !tr && !t && !tl && !l && !r && (!bl || b);
      end
      SIDE_RIGHT: begin
        bord = !r && l;
        irr  = !b && !br && !r && !tr && !t && (!tl || l);
      end
      SIDE_BOTTOM: begin
        bord = !b && t;
        irr  = !l && !bl && !b && !br && !r && (!tr || t);
      end
      default: begin
        bord = !l && r;
        irr  = !t && !tl && !l && !bl && !b && (!br || r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (stat.bad) begin
        m_tdata <= OUT_TDATA_W'(7'b100_0000);
      end else begin
        m_tdata <= OUT_TDATA_W'({1'b0, irr, bord, pop});
      end
    end
  end

endmodule

@@ rtl/neighborhood_3x3_pixel_classifier.sv @@
// Top level of the 3x3 neighborhood pixel classifier.
// Depends on n3pc_pkg, n3pc_ctrl, n3pc_dp (which holds n3pc_ram).
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+------------------------------------
//  s_*     | in  | s_tvalid / s_tready       | tuser op; tdata index, pixel, color, side
//  m_*     | out | m_tvalid / m_tready       | tdata count, border, irregular, bad
//  cfg_*   | in  | cfg_we (no wait)          | cfg_index, cfg_data
//
// A pixel write leaves the block ready for the next request. A query: accept,
// 8 restoring-division steps (index / width), 8 neighbor reads on the one store
// port, a last capture step, then the result; the next request is taken only
// after the result register has it. An out-of-image query index skips the reads.
// Reset clears control and sets width and height to 256, not the pixels.
// A finished query waits while an earlier result is still held on m_tdata.
module neighborhood_3x3_pixel_classifier (
  input  logic                             clk,
  input  logic                             rst,
  // request stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [15:0] index, [23:16] pixel_value, [31:24] color, [33:32] side, rest zero
  input  logic [n3pc_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [0] op: 0 write, 1 query
  input  logic                             s_tuser,
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [3:0] adjacent_count, [4] border_flag, [5] irregular_flag, [6] bad_index
  output logic [n3pc_pkg::OUT_TDATA_W-1:0] m_tdata,
  // config write port: index 0 image_width, 1 image_height
  input  logic                             cfg_we,
  input  logic [n3pc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [n3pc_pkg::CFG_BITS-1:0]    cfg_data
);
  import n3pc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: owns s_tready and the step counter
  n3pc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: divider, addressing, pixel store, flags, result register
  n3pc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ rtl/n3pc_checker.sv @@
// Port-level checks of the 3x3 pixel classifier, bound to the top level.
// Depends on n3pc_pkg and neighborhood_3x3_pixel_classifier_defines.svh.
`include "neighborhood_3x3_pixel_classifier_defines.svh"

module n3pc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             s_tuser,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [n3pc_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import n3pc_pkg::*;

  // a held result does not change
  `N3PC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // an out-of-image result carries nothing else
  `N3PC_ASSERT_NOW(a_bad_zero, m_tvalid && m_tdata[6], m_tdata[5:0] == 6'd0)

  // at most eight neighbors
  `N3PC_ASSERT_NOW(a_count_max, m_tvalid, m_tdata[3:0] <= 4'd8)

  // an accepted query closes the request side
  `N3PC_ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && (s_tuser == OP_QUERY), !s_tready)

endmodule

bind neighborhood_3x3_pixel_classifier n3pc_checker u_n3pc_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking bench for the 3x3 neighborhood pixel classifier: pixel writes
// and neighborhood queries over the request stream, checked against a local model.
// Depends on n3pc_pkg and neighborhood_3x3_pixel_classifier.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import n3pc_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int RESET_CYCLES    = 12;
  localparam int DRAIN_CYCLES    = 40;   // idle time before a geometry change and at the end
  localparam int HOLD_CYCLES     = 300;  // long result back-pressure window
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 185;

  // one query result, field order as in m_tdata from bit 6 down
  typedef struct packed {
    logic       bad;
    logic       irregular;
    logic       border;
    logic [3:0] count;
  } verdict_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // directed stimulus row; wreg/hreg only used by ROW_CFG rows
  typedef struct packed {
    row_kind_t   kind;
    logic        op;
    logic [15:0] idx;
    logic [7:0]  pix;
    logic [7:0]  colour;
    logic [1:0]  side;
    logic        typed;  // want holds the expected verdict
    verdict_t    want;
    logic [8:0]  wreg;
    logic [8:0]  hreg;
  } row_t;

  // every neighbor outside the image: all count as matches, no flag can fire
  localparam verdict_t ALL_OUTSIDE  = '{count: 4'd8, default: '0};
  localparam verdict_t OUT_OF_IMAGE = '{bad: 1'b1, default: '0};
  localparam verdict_t NO_VERDICT   = '0;

  localparam row_t DIRECTED [30] = '{
    // reset geometry 256x256: corner query, its in-image neighbors written first
    '{ROW_REQ, OP_WRITE, 16'd1,     8'd0,   8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd0, 9'd0},
    '{ROW_REQ, OP_WRITE, 16'd256,   8'd0,   8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd0, 9'd0},
    '{ROW_REQ, OP_WRITE, 16'd257,   8'd9,   8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd0, 9'd0},
    '{ROW_REQ, OP_QUERY, 16'd0,     8'd0,   8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd0, 9'd0},
    // 1x1 image: no neighbor inside, any other index is out of the image
    '{ROW_CFG, OP_WRITE, 16'd0,     8'd0,   8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd1, 9'd1},
    '{ROW_REQ, OP_QUERY, 16'd0,     8'd0,   8'd255, SIDE_LEFT,   1'b1, ALL_OUTSIDE, 9'd0, 9'd0},
    '{ROW_REQ, OP_QUERY, 16'd1,     8'd0,   8'd0,   SIDE_TOP,    1'b1, OUT_OF_IMAGE, 9'd0, 9'd0},
    '{ROW_REQ, OP_QUERY, 16'hFFFF,  8'd255, 8'd255, SIDE_LEFT,   1'b1, OUT_OF_IMAGE, 9'd0, 9'd0},
    // zero width and height behave as 1
    '{ROW_CFG, OP_WRITE, 16'd0,     8'd0,   8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd0, 9'd0},
    '{ROW_REQ, OP_QUERY, 16'd0,     8'd0,   8'd0,   SIDE_RIGHT,  1'b1, ALL_OUTSIDE, 9'd0, 9'd0},
    // 3x3 image, fully written
    '{ROW_CFG, OP_WRITE, 16'd0,     8'd0,   8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd3, 9'd3},
    '{ROW_REQ, OP_WRITE, 16'd0,     8'd0,   8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd0, 9'd0},
    '{ROW_REQ, OP_WRITE, 16'd1,     8'd255, 8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd0, 9'd0},
    '{ROW_REQ, OP_WRITE, 16'd2,     8'd0,   8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd0, 9'd0},
    '{ROW_REQ, OP_WRITE, 16'd3,     8'd255, 8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd0, 9'd0},
    '{ROW_REQ, OP_WRITE, 16'd4,     8'd7,   8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd0, 9'd0},
    '{ROW_REQ, OP_WRITE, 16'd5,     8'd0,   8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd0, 9'd0},
    '{ROW_REQ, OP_WRITE, 16'd6,     8'd0,   8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd0, 9'd0},
    '{ROW_REQ, OP_WRITE, 16'd7,     8'd0,   8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd0, 9'd0},
    '{ROW_REQ, OP_WRITE, 16'd8,     8'd255, 8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd0, 9'd0},
    '{ROW_REQ, OP_QUERY, 16'd4,     8'd0,   8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd0, 9'd0},
    '{ROW_REQ, OP_QUERY, 16'd4,     8'd0,   8'd255, SIDE_RIGHT,  1'b0, NO_VERDICT, 9'd0, 9'd0},
    '{ROW_REQ, OP_QUERY, 16'd0,     8'd0,   8'd255, SIDE_BOTTOM, 1'b0, NO_VERDICT, 9'd0, 9'd0},
    // index equal to width*height is the first one outside
    '{ROW_REQ, OP_QUERY, 16'd9,     8'd0,   8'd0,   SIDE_TOP,    1'b1, OUT_OF_IMAGE, 9'd0, 9'd0},
    // writes land anywhere, inside the image or not
    '{ROW_REQ, OP_WRITE, 16'hFFFF,  8'd255, 8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd0, 9'd0},
    // oversize registers clamp to 256x256; last pixel of the store
    '{ROW_CFG, OP_WRITE, 16'd0,     8'd0,   8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd511, 9'd511},
    '{ROW_REQ, OP_WRITE, 16'd65534, 8'd0,   8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd0, 9'd0},
    '{ROW_REQ, OP_WRITE, 16'd65279, 8'd255, 8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd0, 9'd0},
    '{ROW_REQ, OP_WRITE, 16'd65278, 8'd0,   8'd0,   SIDE_TOP,    1'b0, NO_VERDICT, 9'd0, 9'd0},
    '{ROW_REQ, OP_QUERY, 16'hFFFF,  8'd0,   8'd0,   SIDE_LEFT,   1'b0, NO_VERDICT, 9'd0, 9'd0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_BITS-1:0]    cfg_data = '0;

  neighborhood_3x3_pixel_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // local copy of the block state: pixels, which ones hold data, geometry registers
  logic [7:0]  image_mem [STORE_DEPTH];
  bit          pixel_written [STORE_DEPTH];
  logic [8:0]  width_reg  = 9'd256;
  logic [8:0]  height_reg = 9'd256;

  verdict_t    expected_verdicts [$];
  verdict_t    oldest;
  int          mismatches  = 0;
  int          cycle_count = 0;
  int          sent        = 0;   // accepted requests
  bit          calm        = 1'b0; // no idling on either side
  bit          hold_result = 1'b0; // asks the sink for one long stall
  int          zero_pct    = 50;   // share of zero pixels in random writes

  // register value as the block uses it: 0 acts as 1, above MAX_SIDE clamps
  function automatic int span(logic [8:0] v);
    if (v == 9'd0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  function automatic int pick_gap();
    return calm ? 0 : int'($urandom_range(0, 10));
  endfunction

  // zero-heavy palette so that border and irregularity patterns show up
  function automatic logic [7:0] pick_pixel();
    int r = $urandom_range(0, 99);
    if (r < zero_pct) return 8'd0;
    if (r < zero_pct + (100 - zero_pct) / 2) begin
      case ($urandom_range(0, 2))
        0: return 8'd1;
        1: return 8'd2;
        default: return 8'd255;
      endcase
    end
    return 8'($urandom);
  endfunction

  // neighbor outside the image, or equal to the color
  function automatic logic probe(int x, int y, int dx, int dy, int w, int h,
                                 logic [7:0] colour);
    int nx = x + dx;
    int ny = y + dy;
    if (nx < 0 || ny < 0 || nx >= w || ny >= h) return 1'b1;
    return image_mem[16'(ny * w + nx)] == colour;
  endfunction

  function automatic verdict_t classify_pixel(logic [15:0] idx, logic [7:0] colour,
                                              logic [1:0] side);
    verdict_t v;
    int w, h, x, y, sum;
    logic tl, t, tr, l, r, bl, b, br;
    w = span(width_reg);
    h = span(height_reg);
    v = '0;
    if (int'(idx) >= w * h) begin
      v.bad = 1'b1;
      return v;
    end
    x = int'(idx) % w;
    y = int'(idx) / w;
    sum = probe(x, y, -1, -1, w, h, colour) + probe(x, y, 0, -1, w, h, colour)
        + probe(x, y,  1, -1, w, h, colour) + probe(x, y, -1, 0, w, h, colour)
        + probe(x, y,  1,  0, w, h, colour) + probe(x, y, -1, 1, w, h, colour)
        + probe(x, y,  0,  1, w, h, colour) + probe(x, y, 1, 1, w, h, colour);
    v.count = 4'(sum);
    // flags look for color 0, outside counts as 0
    tl = probe(x, y, -1, -1, w, h, 8'd0);
    t  = probe(x, y,  0, -1, w, h, 8'd0);
    tr = probe(x, y,  1, -1, w, h, 8'd0);
    l  = probe(x, y, -1,  0, w, h, 8'd0);
    r  = probe(x, y,  1,  0, w, h, 8'd0);
    bl = probe(x, y, -1,  1, w, h, 8'd0);
    b  = probe(x, y,  0,  1, w, h, 8'd0);
    br = probe(x, y,  1,  1, w, h, 8'd0);
    case (side)
      SIDE_TOP: begin
        v.border    = !t && b;
        v.irregular = !tr && !t && !tl && !l && !r && (!bl || b);
      end
      SIDE_RIGHT: begin
        v.border    = !r && l;
        v.irregular = !b && !br && !r && !tr && !t && (!tl || l);
      end
      SIDE_BOTTOM: begin
        v.border    = !b && t;
        v.irregular = !l && !bl && !b && !br && !r && (!tr || t);
      end
      default: begin
        v.border    = !l && r;
        v.irregular = !t && !tl && !l && !bl && !b && (!br || r);
      end
    endcase
    return v;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, want %0d (cycle %0d)", what, got, want, cycle_count);
    mismatches++;
  endtask

  // Offer one request after a random gap and hold it until accepted. Valid is
  // left high on return so a back-to-back request needs no second assignment.
  task automatic issue(input logic op, input logic [15:0] idx, input logic [7:0] pix,
                       input logic [7:0] colour, input logic [1:0] side,
                       input logic typed, input verdict_t want);
    int gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'd0, side, colour, pix, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    if (op == OP_WRITE) begin
      image_mem[idx]     = pix;
      pixel_written[idx] = 1'b1;
    end else begin
      expected_verdicts.push_back(typed ? want : classify_pixel(idx, colour, side));
    end
  endtask

  // Write every in-image neighbor of idx that was never written, so a query
  // never reads an undefined pixel.
  task automatic fill_around(input logic [15:0] idx);
    int w, h, x, y, nx, ny;
    logic [15:0] a;
    w = span(width_reg);
    h = span(height_reg);
    if (int'(idx) >= w * h) return;
    x = int'(idx) % w;
    y = int'(idx) / w;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        nx = x + dx;
        ny = y + dy;
        if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 && nx < w && ny < h) begin
          a = 16'(ny * w + nx);
          if (!pixel_written[a])
            issue(OP_WRITE, a, pick_pixel(), 8'($urandom), 2'($urandom), 1'b0, NO_VERDICT);
        end
      end
    end
  endtask

  // Geometry changes only on an idle block: all results in, then a drain
  // window since a trailing write gives no result to wait for.
  task automatic set_geometry(input logic [8:0] wv, input logic [8:0] hv);
    s_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= wv;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= hv;
    @(posedge clk);
    cfg_we     <= 1'b0;
    width_reg  = wv;
    height_reg = hv;
  endtask

  // Result sink: random ready gaps, plus one long stall when asked, counted here
  // so the sender keeps pushing requests into a full block meanwhile.
  initial begin : result_sink
    int gap;
    forever begin
      if (hold_result) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_result = 1'b0;
      end
      gap = pick_gap();
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Result checker: each accepted result against the oldest expected verdict.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_verdicts.size() == 0) begin
        flag_mismatch("result with no query pending, m_tdata", int'(m_tdata), 0);
      end else begin
        oldest = expected_verdicts.pop_front();
        if (m_tdata[3:0] !== oldest.count)
          flag_mismatch("adjacent_count", int'(m_tdata[3:0]), int'(oldest.count));
        if (m_tdata[4] !== oldest.border)
          flag_mismatch("border_flag", int'(m_tdata[4]), int'(oldest.border));
        if (m_tdata[5] !== oldest.irregular)
          flag_mismatch("irregular_flag", int'(m_tdata[5]), int'(oldest.irregular));
        if (m_tdata[6] !== oldest.bad)
          flag_mismatch("bad_index", int'(m_tdata[6]), int'(oldest.bad));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : request_source
    int w, h, area, target, r, qx, qy, hot_x, hot_y;
    logic [8:0]  wv, hv;
    logic [15:0] idx;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG)
        set_geometry(DIRECTED[i].wreg, DIRECTED[i].hreg);
      else begin
        issue(DIRECTED[i].op, DIRECTED[i].idx, DIRECTED[i].pix, DIRECTED[i].colour,
              DIRECTED[i].side, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    // random phases, one geometry each; extremes first, then small images, then one random size
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin wv = 9'd256; hv = 9'd256; end
        1: begin wv = 9'd4;   hv = 9'd5;   end
        2: begin wv = 9'd1;   hv = 9'd256; end
        3: begin wv = 9'd256; hv = 9'd1;   end
        4: begin wv = 9'd0;   hv = 9'd511; end
        5: begin wv = 9'd300; hv = 9'd7;   end
        9: begin wv = 9'($urandom_range(1, 256)); hv = 9'($urandom_range(1, 256)); end
        default: begin wv = 9'($urandom_range(1, 16)); hv = 9'($urandom_range(1, 16)); end
      endcase
      set_geometry(wv, hv);
      w     = span(wv);
      h     = span(hv);
      area  = w * h;
      hot_x = $urandom_range(0, w - 1);
      hot_y = $urandom_range(0, h - 1);
      calm  = (phase % 4 == 2);
      zero_pct = $urandom_range(20, 80);
      // small image, back-to-back requests: the block fills up behind the stall
      if (phase == 1) begin
        calm        = 1'b1;
        hold_result = 1'b1;
      end
      target = sent + ITEMS_PER_PHASE;
      while (sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          // pixel write, mostly inside the image
          if ($urandom_range(0, 3) != 0) idx = 16'($urandom_range(0, area - 1));
          else idx = 16'($urandom);
          issue(OP_WRITE, idx, pick_pixel(), 8'($urandom), 2'($urandom), 1'b0, NO_VERDICT);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 40) begin
            // around a hot spot so neighborhoods get reused
            qx = hot_x + int'($urandom_range(0, 6)) - 3;
            qy = hot_y + int'($urandom_range(0, 4)) - 2;
            if (qx >= 0 && qy >= 0 && qx < w && qy < h) idx = 16'(qy * w + qx);
            else idx = 16'($urandom_range(0, area - 1));
          end else if (r < 82) begin
            idx = 16'($urandom_range(0, area - 1));
          end else if (r < 94 && area < STORE_DEPTH) begin
            idx = 16'($urandom_range(area, STORE_DEPTH - 1));
          end else begin
            idx = 16'($urandom);
          end
          fill_around(idx);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: r = 0;
            4, 5:       r = 1;
            6:          r = 255;
            default:    r = $urandom_range(0, 255);
          endcase
          issue(OP_QUERY, idx, 8'($urandom), 8'(r), 2'($urandom), 1'b0, NO_VERDICT);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
